/* sv/etpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpc_pkg: shared types and constants for the escape-time pixel color block
// Fixed-point widths, controller states, datapath command/status structs.
// ----------------------------------------------------------------------------
package etpc_pkg;

    // fraction bits of the point coordinates and of z
    localparam int FRAC_BITS = 28;
    localparam int CW = 32;                       // input coordinate width

    // multiplier operand: |z| < 2.0 once it reaches the multipliers
    localparam int OPW = FRAC_BITS + 2;
    localparam int PW  = 2 * OPW;                 // full product width

    // z register width: holds z*z terms plus a full-range c
    localparam int ZW = ((FRAC_BITS + 4 > CW) ? FRAC_BITS + 4 : CW) + 2;

    localparam logic [7:0] MAX_ITER = 8'd255;

    // color ramp arithmetic
    localparam int TW = 21;                       // 21*n*(510-n) < 2^21
    localparam logic [TW-1:0] SEG_SPAN  = TW'(65025);

    typedef enum logic [2:0] {
        SEG_RED_UP      = 3'd0,
        SEG_GREEN_UP    = 3'd1,
        SEG_RED_DOWN    = 3'd2,
        SEG_BLUE_UP     = 3'd3,
        SEG_GREEN_DOWN  = 3'd4,
        SEG_RED_UP_BLUE = 3'd5,
        SEG_GREEN_UP_MG = 3'd6
    } seg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE,
        ST_QSUB,
        ST_OUTPUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // capture c, z = c, n = 0
        logic mul;        // register x*x, y*y, 2*x*y
        logic upd;        // z = z*z + c, n++
        logic col_init;   // t = 21*n*(510-n), k = 0
        logic q_sub;      // t -= 65025, k++ mod 7
        logic ramp_load;  // ramp = remainder div 255, by reciprocal
    } dp_cmd_t;

    typedef struct packed {
        logic big;       // |x| or |y| >= 2.0
        logic esc;       // x*x + y*y >= 4.0
        logic n_max;     // n reached the iteration cap
        logic q_ge;      // remainder still >= 65025
    } dp_status_t;

endpackage

/* sv/etpc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpc_datapath: iteration and color datapath
// Three shared multipliers for the z step, then a subtract-based color ramp.
// ----------------------------------------------------------------------------
module etpc_datapath
    import etpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic signed [CW-1:0] c_real,
    input  logic signed [CW-1:0] c_imag,
    output dp_status_t           status,
    output logic [7:0]           n_out,
    output seg_t                 seg_out,
    output logic [7:0]           ramp_out
);

    localparam logic signed [ZW-1:0] LIM     = ZW'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NEG_LIM = -LIM;
    localparam logic [ZW-1:0]        FOUR    = ZW'(1) << (FRAC_BITS + 2);

    logic signed [CW-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [ZW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] xx_reg, xx_next, yy_reg, yy_next, xy_reg, xy_next;
    logic [7:0]           n_reg, n_next;
    logic [TW-1:0]        rem_reg, rem_next;
    seg_t                 seg_reg, seg_next;
    logic [7:0]           r_reg, r_next;

    logic signed [OPW-1:0] x_op, y_op;
    logic signed [PW-1:0]  pxx, pyy, pxy, pxx_sh, pyy_sh, pxy_sh;
    logic [16:0]           nn;
    logic [ZW-1:0]         mag_sum;
    logic [15:0]           rem_p1;
    logic [23:0]           ramp_prod;

    // operands are in range whenever the multipliers are used
    assign x_op = $signed(x_reg[OPW-1:0]);
    assign y_op = $signed(y_reg[OPW-1:0]);
    assign pxx  = x_op * x_op;
    assign pyy  = y_op * y_op;
    assign pxy  = x_op * y_op;
    // arithmetic shift = floor
    assign pxx_sh = pxx >>> FRAC_BITS;
    assign pyy_sh = pyy >>> FRAC_BITS;
    assign pxy_sh = pxy >>> (FRAC_BITS - 1);

    assign mag_sum = ZW'(xx_reg + yy_reg);
    assign nn      = 17'(n_reg) * (17'd510 - 17'(n_reg));

    // rem < 65025 here: rem div 255 = ((rem + 1) * 257) >> 16, exact
    assign rem_p1    = 16'(rem_reg) + 16'd1;
    assign ramp_prod = {rem_p1, 8'd0} + 24'(rem_p1);

    always_comb
    begin
        cr_next   = cr_reg;
        ci_next   = ci_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        xx_next   = xx_reg;
        yy_next   = yy_reg;
        xy_next   = xy_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        seg_next  = seg_reg;
        r_next    = r_reg;
        if (cmd.load)
        begin
            cr_next = c_real;
            ci_next = c_imag;
            x_next  = ZW'(c_real);
            y_next  = ZW'(c_imag);
            n_next  = 8'd0;
        end
        if (cmd.mul)
        begin
            xx_next = ZW'(pxx_sh);
            yy_next = ZW'(pyy_sh);
            xy_next = ZW'(pxy_sh);
        end
        if (cmd.upd)
        begin
            x_next = xx_reg - yy_reg + ZW'(cr_reg);
            y_next = xy_reg + ZW'(ci_reg);
            n_next = n_reg + 8'd1;
        end
        if (cmd.col_init)
        begin
            rem_next = TW'(nn) * TW'(21);
            seg_next = SEG_RED_UP;
        end
        if (cmd.q_sub)
        begin
            rem_next = rem_reg - SEG_SPAN;
            seg_next = (seg_reg == SEG_GREEN_UP_MG) ? SEG_RED_UP : seg_t'(seg_reg + 3'd1);
        end
        if (cmd.ramp_load)
        begin
            r_next = ramp_prod[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= 8'd0;
        end
        else
        begin
            r_reg <= r_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        xx_reg  <= xx_next;
        yy_reg  <= yy_next;
        xy_reg  <= xy_next;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        seg_reg <= seg_next;
    end

    assign status.big      = (x_reg >= LIM) || (x_reg <= NEG_LIM) ||
                             (y_reg >= LIM) || (y_reg <= NEG_LIM);
    assign status.esc      = (mag_sum >= FOUR);
    assign status.n_max    = (n_reg == MAX_ITER);
    assign status.q_ge     = (rem_reg >= SEG_SPAN);

    assign n_out    = n_reg;
    assign seg_out  = seg_reg;
    assign ramp_out = r_reg;

endmodule

/* sv/etpc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpc_ctrl: sequencer for the escape-time block
// Steps the datapath through iteration, color ramp and result hand-off.
// ----------------------------------------------------------------------------
module etpc_ctrl
    import etpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    input  logic       out_free,
    output dp_cmd_t    cmd,
    output logic       out_load
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.n_max || status.big)
                begin
                    cmd.col_init = 1'b1;
                    state_next   = ST_QSUB;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.esc)
                begin
                    cmd.col_init = 1'b1;
                    state_next   = ST_QSUB;
                end
                else
                begin
                    cmd.upd    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_QSUB:
            begin
                if (status.q_ge)
                begin
                    cmd.q_sub = 1'b1;
                end
                else
                begin
                    cmd.ramp_load = 1'b1;
                    state_next    = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/escape_time_pixel_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_pixel_color: escape count and palette color for one point c
// Iterates z = z*z + c from z = c in Q4.28 and maps the count to RGB.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, c_real, c_imag): one beat is one point.
//   Output channel (out_valid/out_ready, iterations, red, green, blue): one
//   beat per point, in input order.
//   One point is in flight at a time. in_ready is high only while the
//   sequencer is idle.
//   Each iteration is a multiply step, which also makes the magnitude and
//   count tests, then an add/compare/update step, which also makes the |z|^2
//   test, on one shared set of three 30x30 multipliers. The point stops at
//   one of these tests with escape count n (at most 255). Then follow q
//   subtract steps for the ramp segment, q = 21n(510-n) div 65025 (0..21),
//   a step for the ramp value and a step that loads the output register.
//   The result sits in an output register; the next point is accepted as soon
//   as that result is handed to the register, even while the receiver stalls.
//   A finished result waits in the sequencer until the register is free.
//   Reset clears the sequencer and the output valid; no results are pending.
// ----------------------------------------------------------------------------
module escape_time_pixel_color
    import etpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] c_real,
    input  logic signed [CW-1:0] c_imag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           iterations,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       out_load;
    logic       out_free;
    logic [7:0] n_val, ramp;
    seg_t       seg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] iter_reg, red_reg, green_reg, blue_reg;
    logic [7:0] red_c, green_c, blue_c;

    // output register can take a new beat when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    etpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .out_free (out_free),
        .cmd      (cmd),
        .out_load (out_load)
    );

    etpc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .c_real   (c_real),
        .c_imag   (c_imag),
        .status   (status),
        .n_out    (n_val),
        .seg_out  (seg),
        .ramp_out (ramp)
    );

    // seven-segment palette
    always_comb
    begin
        case (seg)
            SEG_RED_UP:      begin red_c = ramp;         green_c = 8'd0;         blue_c = 8'd0;   end
            SEG_GREEN_UP:    begin red_c = 8'd255;       green_c = ramp;         blue_c = 8'd0;   end
            SEG_RED_DOWN:    begin red_c = 8'd255 - ramp; green_c = 8'd255;      blue_c = 8'd0;   end
            SEG_BLUE_UP:     begin red_c = 8'd0;         green_c = 8'd255;       blue_c = ramp;   end
            SEG_GREEN_DOWN:  begin red_c = 8'd0;         green_c = 8'd255 - ramp; blue_c = 8'd255; end
            SEG_RED_UP_BLUE: begin red_c = ramp;         green_c = 8'd0;         blue_c = 8'd255; end
            SEG_GREEN_UP_MG: begin red_c = 8'd255;       green_c = ramp;         blue_c = 8'd255; end
            default:         begin red_c = 8'd0;         green_c = 8'd0;         blue_c = 8'd0;   end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            iter_reg  <= n_val;
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign iterations = iter_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

endmodule
